/* rtl/hlsh_pkg.sv */
// ----------------------------------------------------------------------------
// hlsh_pkg
// shared constants, codes and the chain transaction type of the
// hyperplane lsh signature block
// ----------------------------------------------------------------------------
package hlsh_pkg;

    localparam int MAX_DIMS_DEF = 16;
    localparam int MAX_BITS_DEF = 64;

    localparam int VAL_W   = 16;
    localparam int PLANE_W = 6;
    localparam int IDX_W   = 6;
    localparam int SIG_W   = 64;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int DCNT_W  = 7;
    localparam int DIMS_W  = 5;
    localparam int BITS_W  = 7;
    localparam int CFG_W   = 7;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    localparam logic REG_DIMS = 1'b0;
    localparam logic REG_BITS = 1'b1;

    typedef struct packed {
        logic                     vld;
        logic                     comp;
        logic                     last;
        logic [PLANE_W-1:0]       plane;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  val;
        logic [SIG_W-1:0]         sig;
    } hlsh_tok_t;

endpackage

/* rtl/hlsh_cell.sv */
// ----------------------------------------------------------------------------
// hlsh_cell
// one hyperplane: coefficient store, multiplier and accumulator; the
// transaction passes through two stages and leaves with this plane's bit
// ----------------------------------------------------------------------------
module hlsh_cell #(
    parameter int MAX_DIMS = hlsh_pkg::MAX_DIMS_DEF,
    parameter int CELL_ID  = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  hlsh_pkg::hlsh_tok_t tok_in,
    output hlsh_pkg::hlsh_tok_t tok_out
);
    import hlsh_pkg::*;

    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic signed [VAL_W-1:0]  coef_mem [MAX_DIMS];
    logic signed [VAL_W-1:0]  coef_rd;
    logic                     idx_ok;
    logic                     wr_hit;
    logic [AW-1:0]            addr;

    hlsh_tok_t                tka_reg;
    hlsh_tok_t                tkb_reg;
    hlsh_tok_t                tkb_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  sum;
    logic                     pos;

    assign addr   = tok_in.idx[AW-1:0];
    assign idx_ok = (DCNT_W'(tok_in.idx) < DCNT_W'(MAX_DIMS));
    assign wr_hit = en && tok_in.vld && (tok_in.comp == FUNC_LOAD) && idx_ok
                    && (tok_in.plane == PLANE_W'(CELL_ID));
    assign coef_rd = coef_mem[addr];

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            coef_mem[addr] <= tok_in.val;
        end
    end

    always_comb
    begin
        prod_next = '0;
        if (tok_in.comp == FUNC_POINT && idx_ok)
        begin
            prod_next = PROD_W'(coef_rd) * PROD_W'(tok_in.val);
        end
    end

    assign sum = acc_reg + ACC_W'(prod_reg);
    assign pos = !sum[ACC_W-1] && (sum != '0);

    always_comb
    begin
        tkb_next = tka_reg;
        acc_next = acc_reg;
        if (tka_reg.vld && tka_reg.comp == FUNC_POINT)
        begin
            if (tka_reg.last)
            begin
                tkb_next.sig[CELL_ID] = pos;
                acc_next              = '0;
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tka_reg  <= '0;
            tkb_reg  <= '0;
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else if (en)
        begin
            tka_reg  <= tok_in;
            prod_reg <= prod_next;
            tkb_reg  <= tkb_next;
            acc_reg  <= acc_next;
        end
    end

    assign tok_out = tkb_reg;

endmodule

/* rtl/hyperplane_lsh_signature.sv */
// ----------------------------------------------------------------------------
// hyperplane_lsh_signature
// random-hyperplane lsh signature over streamed point components
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------
// in       | in_valid/in_ready   | func, plane, dim, value
// out      | out_valid/out_ready | signature
// cfg      | cfg_write           | cfg_index, cfg_data
//
// one transaction per cycle while in_ready is high; a signature passes through
// two stages per hyperplane cell, the first loaded at the edge that accepts the
// last component of its point, then the output register
// reset clears count, accumulators, chain and output; coefficients hold until written
// a waiting signature stalls the chain and drops in_ready only once the next
// signature reaches the chain end
// ----------------------------------------------------------------------------
module hyperplane_lsh_signature #(
    parameter int MAX_DIMS = hlsh_pkg::MAX_DIMS_DEF,
    parameter int MAX_BITS = hlsh_pkg::MAX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [hlsh_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [5:0]                  plane,
    input  logic [3:0]                  dim,
    input  logic signed [15:0]          value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [63:0]                 signature
);
    import hlsh_pkg::*;

    localparam int CW = $clog2(MAX_DIMS + 1);

    logic [DIMS_W-1:0]  dims_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [DCNT_W-1:0]  eff_dims;
    logic [BITS_W-1:0]  eff_bits;
    logic               entry_last;
    logic               en;
    logic               accept;
    logic               chain_res;
    logic               out_valid_reg;
    logic [SIG_W-1:0]   sig_reg;
    logic [SIG_W-1:0]   mask;
    hlsh_tok_t          head_tok;
    hlsh_tok_t          tok [MAX_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_W'(2);
            bits_reg <= BITS_W'(32);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIMS: dims_reg <= cfg_data[DIMS_W-1:0];
                REG_BITS: bits_reg <= cfg_data[BITS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        eff_dims = DCNT_W'(dims_reg);
        if (dims_reg == '0)
        begin
            eff_dims = DCNT_W'(1);
        end
        else if (DCNT_W'(dims_reg) > DCNT_W'(MAX_DIMS))
        begin
            eff_dims = DCNT_W'(MAX_DIMS);
        end
    end

    assign eff_bits   = (bits_reg > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : bits_reg;
    assign entry_last = (DCNT_W'(cnt_reg) + DCNT_W'(1)) >= eff_dims;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && func == FUNC_POINT)
        begin
            cnt_next = entry_last ? '0 : cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        head_tok       = '0;
        head_tok.vld   = in_valid;
        head_tok.comp  = func;
        head_tok.last  = entry_last;
        head_tok.plane = plane;
        head_tok.idx   = (func == FUNC_POINT) ? IDX_W'(cnt_reg) : IDX_W'(dim);
        head_tok.val   = value;
    end

    assign tok[0] = head_tok;

    for (genvar g = 0; g < MAX_BITS; g++)
    begin : g_cell
        hlsh_cell #(
            .MAX_DIMS (MAX_DIMS),
            .CELL_ID  (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < SIG_W; i++)
        begin
            mask[i] = (BITS_W'(i) < eff_bits);
        end
    end

    assign chain_res = tok[MAX_BITS].vld && (tok[MAX_BITS].comp == FUNC_POINT)
                       && tok[MAX_BITS].last;

    // output register, loaded whenever it is empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sig_reg       <= '0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= chain_res;
            if (chain_res)
            begin
                sig_reg <= tok[MAX_BITS].sig & mask;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign signature = sig_reg;
    assign en        = !chain_res || !out_valid_reg || out_ready;
    assign in_ready  = en;

    a_cnt_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_POINT && entry_last |=> cnt_reg == '0)
        else $error("component count not cleared after last component");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        DCNT_W'(cnt_reg) < DCNT_W'(MAX_DIMS))
        else $error("component count out of range");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(tok[MAX_BITS]))
        else $error("chain end moved while output stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(signature))
        else $error("signature dropped or changed while stalled");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hyperplane lsh signature block: fills the
// coefficient table, runs directed points over the register corner cases,
// then random point and load streams under several idle and stall phases,
// comparing every signature with an in-bench signed-accumulator predictor
// ----------------------------------------------------------------------------
module tb;

    import hlsh_pkg::*;

    localparam int N_PLANES    = MAX_BITS_DEF;
    localparam int N_DIMS      = MAX_DIMS_DEF;
    localparam int DRAIN_WAIT  = 2 * MAX_BITS_DEF + 32;
    localparam int HOLD_CYCLES = 600;
    localparam int PRESS_ITEMS = 200;
    localparam int PHASE_ITEMS = 20;

    typedef struct {
        logic                    func;
        logic [5:0]              plane;
        logic [3:0]              dim;
        logic signed [15:0]      value;
    } lsh_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_index = REG_DIMS;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = FUNC_LOAD;
    logic [5:0]         plane = '0;
    logic [3:0]         dim = '0;
    logic signed [15:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [63:0]        signature;

    lsh_item_t          pending_items[$];
    lsh_item_t          offered_item;
    logic [63:0]        expected_signatures[$];
    logic [63:0]        want_sig;

    logic signed [15:0] coef_table [N_PLANES][N_DIMS];
    longint             plane_sums [N_PLANES];
    int unsigned        comps_seen = 0;
    logic [DIMS_W-1:0]  dims_reg = 5'd2;
    logic [BITS_W-1:0]  bits_reg = 7'd32;

    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 mismatch_count = 0;
    logic               hold_go = 1'b0;
    int                 hold_left = 0;

    hyperplane_lsh_signature u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .plane     (plane),
        .dim       (dim),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .signature (signature)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void absorb_item(input lsh_item_t it);
        int          k;
        int unsigned n_dims;
        int unsigned n_bits;
        logic [63:0] sig;
        if (it.func == FUNC_LOAD)
        begin
            coef_table[it.plane][it.dim] = it.value;
            return;
        end
        k = comps_seen;
        if (k < N_DIMS)
        begin
            for (int i = 0; i < N_PLANES; i++)
                plane_sums[i] += longint'(coef_table[i][k]) * longint'(it.value);
        end
        comps_seen = (k + 1) & 31;
        n_dims = (dims_reg == 0) ? 1 : ((dims_reg > N_DIMS) ? N_DIMS : dims_reg);
        if (k + 1 < n_dims)
            return;
        n_bits = (bits_reg > N_PLANES) ? N_PLANES : bits_reg;
        sig = '0;
        for (int i = 0; i < n_bits; i++)
            if (plane_sums[i] > 0)
                sig[i] = 1'b1;
        expected_signatures.push_back(sig);
        foreach (plane_sums[i])
            plane_sums[i] = 0;
        comps_seen = 0;
    endfunction

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'($urandom_range(15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic f, input logic [5:0] p, input logic [3:0] d,
                              input logic signed [15:0] v);
        lsh_item_t it;
        it.func  = f;
        it.plane = p;
        it.dim   = d;
        it.value = v;
        pending_items.push_back(it);
    endtask

    task automatic queue_point(input logic signed [15:0] v);
        queue_item(FUNC_POINT, 6'($urandom), 4'($urandom), v);
    endtask

    task automatic queue_random(input int n);
        repeat (n)
        begin
            if ($urandom_range(99) < 12)
                queue_item(FUNC_LOAD, 6'($urandom), 4'($urandom), rand_value());
            else
                queue_point(rand_value());
        end
    endtask

    task automatic set_reg(input logic idx, input int unsigned val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_DIMS)
            dims_reg = DIMS_W'(val);
        else
            bits_reg = BITS_W'(val);
    endtask

    // wait for every transaction and signature, then let the cell chain empty
    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_signatures.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_item(offered_item);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered_item = pending_items.pop_front();
                    func     <= offered_item.func;
                    plane    <= offered_item.plane;
                    dim      <= offered_item.dim;
                    value    <= offered_item.value;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_signatures.size() == 0)
            begin
                note_mismatch("unexpected signature", '0, signature);
            end
            else
            begin
                want_sig = expected_signatures.pop_front();
                if (signature !== want_sig)
                    note_mismatch("signature", want_sig, signature);
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned ph_dims;
        int unsigned ph_bits;
        foreach (plane_sums[i])
            plane_sums[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full coefficient table so no point reads an unwritten entry
        set_reg(REG_DIMS, 2);
        set_reg(REG_BITS, 64);
        @(negedge clk);
        for (int p = 0; p < N_PLANES; p++)
            for (int d = 0; d < N_DIMS; d++)
                queue_item(FUNC_LOAD, 6'(p), 4'(d), rand_value());
        settle();

        // field extremes, all-zero sums, loads in the middle of a point
        queue_point(16'sh7fff);
        queue_point(16'sh8000);
        queue_point(16'sh0000);
        queue_point(16'sh0000);
        queue_point(16'sh7fff);
        queue_item(FUNC_LOAD, 6'd5, 4'd1, 16'sh8000);
        queue_item(FUNC_LOAD, 6'd63, 4'd1, 16'sh7fff);
        queue_point(16'sh8000);
        settle();

        // zero count acts as one, zero bits gives an empty signature
        set_reg(REG_DIMS, 0);
        set_reg(REG_BITS, 0);
        @(negedge clk);
        queue_point(16'sd12345);
        queue_point(16'sh8000);
        settle();

        // both registers above their maximum
        set_reg(REG_DIMS, 31);
        set_reg(REG_BITS, 127);
        @(negedge clk);
        repeat (N_DIMS) queue_point(rand_value());
        settle();

        // count lowered while a point is partly received
        set_reg(REG_DIMS, 16);
        set_reg(REG_BITS, 1);
        @(negedge clk);
        repeat (5) queue_point(rand_value());
        settle();
        set_reg(REG_DIMS, 3);
        @(negedge clk);
        queue_point(rand_value());
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin ph_dims = 16; ph_bits = 64; end
                1: begin ph_dims = 1;  ph_bits = 64; end
                2: begin ph_dims = 5;  ph_bits = 33; end
                3: begin ph_dims = $urandom_range(31); ph_bits = $urandom_range(127); end
                4: begin ph_dims = 2;  ph_bits = $urandom_range(1, 64); end
                default: begin ph_dims = 8; ph_bits = 64; end
            endcase
            set_reg(REG_DIMS, ph_dims);
            set_reg(REG_BITS, ph_bits);
            @(negedge clk);
            case (ph)
                1: begin sender_idle_pct = 82; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 82; end
                3, 5: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            queue_random((ph == 0) ? PRESS_ITEMS : PHASE_ITEMS);
            if (ph == 0)
            begin
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            settle();
        end

        if (mismatch_count == 0 && expected_signatures.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
